@@ rtl/fhlu_pkg.sv @@
// Shared constants, codes and types for the FIFO handoff lock unit.
package fhlu_pkg;

  localparam int ID_BITS     = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_QUERY   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_OWNER = 3'd4,
    ST_HANDED    = 3'd5,
    ST_RELEASED  = 3'd6,
    ST_QUERY     = 3'd7
  } status_t;

  typedef struct packed {
    logic load_req;  // capture the request word and read the queue head
    logic execute;   // apply the request and register its result
  } ctrl_cmd_t;

endpackage

@@ rtl/fhlu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fhlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fhlu_ctrl.sv @@
// Controller state machine: sequences accept, execute and the result strobe.
module fhlu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output fhlu_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    cmd.load_req = 1'b0;
    cmd.execute  = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.execute;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

@@ rtl/fhlu_datapath.sv @@
// Datapath: lock owner, wait queue pointers and count, and the result registers.
module fhlu_datapath (
  input  logic                clk,
  input  logic                rst,
  input  fhlu_pkg::ctrl_cmd_t cmd,
  input  logic [1:0]          func,
  input  logic [3:0]          requester_id,
  output logic [2:0]          status,
  output logic [3:0]          woken_id,
  output logic                caller_owns,
  output logic                lock_busy
);

  localparam int IB = fhlu_pkg::ID_BITS;
  localparam int PB = fhlu_pkg::PTR_BITS;
  localparam int CB = fhlu_pkg::CNT_BITS;

  logic [1:0]    req_func;
  logic [IB-1:0] req_id;

  logic          lock_held;
  logic [IB-1:0] owner_id;
  logic [PB-1:0] fifo_head;
  logic [PB-1:0] fifo_tail;
  logic [CB-1:0] waiting_count;

  logic          lock_held_next;
  logic [IB-1:0] owner_id_next;
  logic [PB-1:0] fifo_head_next;
  logic [PB-1:0] fifo_tail_next;
  logic [CB-1:0] waiting_count_next;
  logic [2:0]    status_next;
  logic [IB-1:0] woken_next;

  logic          owns;
  logic          push;
  logic [IB-1:0] head_data;

  fhlu_ram #(
    .WIDTH (IB),
    .DEPTH (fhlu_pkg::QUEUE_DEPTH),
    .AW    (PB)
  ) u_wait_fifo (
    .clk   (clk),
    .we    (push),
    .waddr (fifo_tail),
    .wdata (req_id),
    .re    (cmd.load_req),
    .raddr (fifo_head),
    .rdata (head_data)
  );

  function automatic logic [PB-1:0] next_slot(input logic [PB-1:0] p);
    return (p == PB'(fhlu_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PB'(1);
  endfunction

  assign owns = lock_held && (owner_id == req_id);

  always_comb begin
    lock_held_next     = lock_held;
    owner_id_next      = owner_id;
    fifo_head_next     = fifo_head;
    fifo_tail_next     = fifo_tail;
    waiting_count_next = waiting_count;
    woken_next         = '0;
    push               = 1'b0;
    status_next        = fhlu_pkg::ST_QUERY;
    case (req_func)
      fhlu_pkg::FUNC_ACQUIRE: begin
        if (owns) begin
          status_next = fhlu_pkg::ST_ALREADY;
        end else if (!lock_held) begin
          lock_held_next = 1'b1;
          owner_id_next  = req_id;
          status_next    = fhlu_pkg::ST_GRANTED;
        end else if (waiting_count < CB'(fhlu_pkg::QUEUE_DEPTH)) begin
          push               = cmd.execute;
          fifo_tail_next     = next_slot(fifo_tail);
          waiting_count_next = waiting_count + CB'(1);
          status_next        = fhlu_pkg::ST_QUEUED;
        end else begin
          status_next = fhlu_pkg::ST_FULL;
        end
      end
      fhlu_pkg::FUNC_RELEASE: begin
        if (!owns) begin
          status_next = fhlu_pkg::ST_NOT_OWNER;
        end else if (waiting_count != '0) begin
          // hand the lock straight to the oldest waiter
          woken_next         = head_data;
          owner_id_next      = head_data;
          fifo_head_next     = next_slot(fifo_head);
          waiting_count_next = waiting_count - CB'(1);
          status_next        = fhlu_pkg::ST_HANDED;
        end else begin
          lock_held_next = 1'b0;
          owner_id_next  = '0;
          status_next    = fhlu_pkg::ST_RELEASED;
        end
      end
      default: begin
        status_next = fhlu_pkg::ST_QUERY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func <= func;
      req_id   <= requester_id[IB-1:0];
    end
    if (cmd.execute) begin
      status      <= status_next;
      woken_id    <= 4'(woken_next);
      caller_owns <= lock_held_next && (owner_id_next == req_id);
      lock_busy   <= lock_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_held     <= 1'b0;
      owner_id      <= '0;
      fifo_head     <= '0;
      fifo_tail     <= '0;
      waiting_count <= '0;
    end else if (cmd.execute) begin
      lock_held     <= lock_held_next;
      owner_id      <= owner_id_next;
      fifo_head     <= fifo_head_next;
      fifo_tail     <= fifo_tail_next;
      waiting_count <= waiting_count_next;
    end
  end

endmodule

@@ rtl/fifo_handoff_lock_unit.sv @@
// Top level of the FIFO handoff lock unit: controller plus datapath.
// A request (func, requester_id) is taken at a clock edge where start is high
// and busy is low. Busy then stays high while it executes, and the result
// appears on status, woken_id, caller_owns and lock_busy for exactly one cycle
// with done high, the cycle after that; the receiver must take it then, it
// cannot be held. A new request may be started in that same done cycle, but
// not while busy. The accept and execute steps come from the wait queue
// memory: its head entry is read with registered output at accept, and the
// request is applied in the execute cycle that follows. An acquire on a lock
// held by another id queues the caller (status queued) or, with the queue
// full, reports queue full; a release by the owner hands the lock to the
// oldest waiter and reports its id on woken_id, or frees the lock.
module fifo_handoff_lock_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [3:0] requester_id,
  output logic       done,
  output logic [2:0] status,
  output logic [3:0] woken_id,
  output logic       caller_owns,
  output logic       lock_busy
);

  fhlu_pkg::ctrl_cmd_t cmd;

  fhlu_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fhlu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .func         (func),
    .requester_id (requester_id),
    .status       (status),
    .woken_id     (woken_id),
    .caller_owns  (caller_owns),
    .lock_busy    (lock_busy)
  );

endmodule

@@ rtl/fhlu_checker.sv @@
// Port-level checker for the FIFO handoff lock unit, bound to the top level.
module fhlu_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic [3:0] woken_id,
  input logic       caller_owns,
  input logic       lock_busy
);

  // every accepted request is followed by its done strobe after the execute step
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted request produced no result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_woken_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != fhlu_pkg::ST_HANDED) |-> (woken_id == 4'd0))
    else $error("woken id set without a handover");

  a_grant_owns: assert property (@(posedge clk) disable iff (rst)
    (done && (status == fhlu_pkg::ST_GRANTED || status == fhlu_pkg::ST_ALREADY))
      |-> (caller_owns && lock_busy))
    else $error("grant without ownership");

  a_release_free: assert property (@(posedge clk) disable iff (rst)
    (done && status == fhlu_pkg::ST_RELEASED) |-> (!lock_busy && !caller_owns))
    else $error("release left the lock held");

endmodule

bind fifo_handoff_lock_unit fhlu_checker u_fhlu_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .woken_id    (woken_id),
  .caller_owns (caller_owns),
  .lock_busy   (lock_busy)
);
